// ===== sv/tak_pkg.sv =====
`default_nettype none
package tak_pkg;

  localparam int FRAC_BITS = 16;
  // Dividend of a gain: a covariance entry shifted up by the fraction bits.
  localparam int NUM_W = 32 + FRAC_BITS;
  // Gain denominator: covariance plus an unsigned 31-bit variance.
  localparam int DEN_W = 34;
  // Working width of sums ahead of saturation.
  localparam int SW = 52;
  localparam int PW = 66;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV0, S_W0, S_DIV1, S_W1, S_DY,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9, S_M10,
    S_M11, S_M12, S_M13, S_M14, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    REG_MEAS_VAR  = 2'd0,
    REG_RATE_VAR  = 2'd1,
    REG_INIT_BIAS = 2'd2,
    REG_INTERVAL  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
    logic               ovf;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    if (v > SW'(64'sd2147483647)) return 32'sh7fffffff;
    if (v < -SW'(64'sd2147483648)) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic ovf32(input logic signed [SW-1:0] v);
    return (v > SW'(64'sd2147483647)) || (v < -SW'(64'sd2147483648));
  endfunction

endpackage
`default_nettype wire

// ===== sv/tak_if.sv =====
`default_nettype none
interface tak_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] meas_angle;
  logic signed [31:0] gyro_rate;
  modport source (output valid, req_type, meas_angle, gyro_rate, input ready);
  modport sink (input valid, req_type, meas_angle, gyro_rate, output ready);
endinterface

interface tak_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] est_angle;
  logic signed [31:0] est_bias;
  logic               saturated;
  modport source (output valid, est_angle, est_bias, saturated, input ready);
  modport sink (input valid, est_angle, est_bias, saturated, output ready);
endinterface
`default_nettype wire

// ===== sv/tak_div.sv =====
`default_nettype none
// Signed restoring divider, one quotient bit a cycle, truncating toward zero.
// The quotient is saturated to signed 32 bits.
module tak_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tak_pkg::div_req_t req,
  output tak_pkg::div_rsp_t      rsp
);
  localparam int NW = tak_pkg::NUM_W;
  localparam int DW = tak_pkg::DEN_W;
  localparam int CW = $clog2(NW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] qn;
  logic [DW:0]   rem;
  logic [DW-1:0] dmag;
  logic          neg;

  logic [DW:0]   rem_sh;
  logic          take;
  logic [DW:0]   rem_next;
  logic [NW-1:0] qn_next;

  always_comb begin
    rem_sh   = {rem[DW-1:0], qn[NW-1]};
    take     = rem_sh >= {1'b0, dmag};
    rem_next = take ? rem_sh - {1'b0, dmag} : rem_sh;
    qn_next  = {qn[NW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= busy && !req.start && (cnt == CW'(NW - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        qn   <= req.num[NW-1] ? NW'(-req.num) : NW'(req.num);
        dmag <= req.den[DW-1] ? DW'(-req.den) : DW'(req.den);
        neg  <= req.num[NW-1] ^ req.den[DW-1];
      end else if (busy) begin
        rem <= rem_next;
        qn  <= qn_next;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          if (!neg) begin
            rsp.ovf <= qn_next > NW'(32'h7fffffff);
            rsp.quo <= (qn_next > NW'(32'h7fffffff)) ? 32'sh7fffffff : qn_next[31:0];
          end else begin
            rsp.ovf <= qn_next > NW'(33'h080000000);
            rsp.quo <= (qn_next > NW'(33'h080000000)) ? 32'sh80000000
                                                       : 32'(-qn_next[31:0]);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/tilt_angle_kalman_filter.sv =====
`default_nettype none
// Two-state tilt Kalman filter (angle and gyro bias) in signed Q16.16.
// Items enter on the sample channel: req_type 0 is a filter update with an
// accelerometer angle and a gyro rate, req_type 1 restarts the state from
// the configuration registers. Each item gives exactly one item on the
// result channel: the corrected angle, the corrected bias and a saturation
// flag. Registers are written through cfg_we, cfg_index and cfg_data, by
// the user only while the block is idle; the block does not enforce this.
// The block takes one item at a time. An update runs two gain divisions,
// each a start, 48 quotient bits on a bit-serial divider and a capture,
// then steps on one shared 33x33 multiplier with a rounding and saturating
// adder behind it, and then the output load; a zero gain denominator skips
// the divisions. A restart goes straight to the output load. The next item
// can be accepted in the cycle after the result is loaded.
// Reset loads the register defaults and the initial filter state.
// A finished result sits in an output register; the next item is accepted
// while it waits, and that item's result holds in the last step until the
// receiver takes the earlier one.
module tilt_angle_kalman_filter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  tak_in_if.sink           sample,
  tak_out_if.source        result
);
  localparam int SW = tak_pkg::SW;
  localparam int PW = tak_pkg::PW;
  localparam int FB = tak_pkg::FRAC_BITS;

  logic [30:0]        meas_variance;
  logic [30:0]        rate_variance;
  logic signed [31:0] initial_bias;
  logic [31:0]        update_interval;

  logic signed [31:0] pred_angle, pred_bias, cov_00, cov_01, cov_10, cov_11;
  logic signed [31:0] y, u, g0, g1, dy, ea, eb, q00, q01, q10, q11;
  logic signed [31:0] m00, m01, n10, n00;
  logic [31:0]        dd;
  logic signed [SW-1:0] t;
  logic               flag;

  tak_pkg::state_t state, state_next;
  tak_pkg::div_req_t div_req;
  tak_pkg::div_rsp_t div_rsp;

  logic signed [32:0] mul_a, mul_b;
  logic               mul_s32;
  logic signed [PW-1:0] prod;
  logic                 rsh32;
  logic signed [SW-1:0] r;
  logic signed [tak_pkg::DEN_W-1:0] den;
  logic accept, load_out;

  tak_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign den = tak_pkg::DEN_W'(cov_00) + tak_pkg::DEN_W'({1'b0, meas_variance});
  assign sample.ready = (state == tak_pkg::S_IDLE);
  assign accept = sample.valid && sample.ready;
  assign load_out = (state == tak_pkg::S_FIN) && (!result.valid || result.ready);

  always_comb begin
    div_req.start = (state == tak_pkg::S_DIV0) || (state == tak_pkg::S_DIV1);
    div_req.num   = (state == tak_pkg::S_DIV1)
                  ? tak_pkg::NUM_W'(cov_10) <<< FB : tak_pkg::NUM_W'(cov_00) <<< FB;
    div_req.den   = den;
  end

  always_comb begin
    state_next = state;
    case (state)
      tak_pkg::S_IDLE: begin
        if (accept) begin
          if (sample.req_type) state_next = tak_pkg::S_FIN;
          else if (den == '0) state_next = tak_pkg::S_DY;
          else state_next = tak_pkg::S_DIV0;
        end
      end
      tak_pkg::S_DIV0: state_next = tak_pkg::S_W0;
      tak_pkg::S_W0:   if (div_rsp.done) state_next = tak_pkg::S_DIV1;
      tak_pkg::S_DIV1: state_next = tak_pkg::S_W1;
      tak_pkg::S_W1:   if (div_rsp.done) state_next = tak_pkg::S_DY;
      tak_pkg::S_DY:   state_next = tak_pkg::S_M1;
      tak_pkg::S_M1:   state_next = tak_pkg::S_M2;
      tak_pkg::S_M2:   state_next = tak_pkg::S_M3;
      tak_pkg::S_M3:   state_next = tak_pkg::S_M4;
      tak_pkg::S_M4:   state_next = tak_pkg::S_M5;
      tak_pkg::S_M5:   state_next = tak_pkg::S_M6;
      tak_pkg::S_M6:   state_next = tak_pkg::S_M7;
      tak_pkg::S_M7:   state_next = tak_pkg::S_M8;
      tak_pkg::S_M8:   state_next = tak_pkg::S_M9;
      tak_pkg::S_M9:   state_next = tak_pkg::S_M10;
      tak_pkg::S_M10:  state_next = tak_pkg::S_M11;
      tak_pkg::S_M11:  state_next = tak_pkg::S_M12;
      tak_pkg::S_M12:  state_next = tak_pkg::S_M13;
      tak_pkg::S_M13:  state_next = tak_pkg::S_M14;
      tak_pkg::S_M14:  state_next = tak_pkg::S_FIN;
      tak_pkg::S_FIN:  if (load_out) state_next = tak_pkg::S_IDLE;
      default:         state_next = tak_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tak_pkg::S_IDLE;
    else state <= state_next;
  end

  // Operand selection for the shared multiplier. Products with the interval
  // or with its square dd are Q0.32 and drop 32 bits; the others drop the fraction bits.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_s32 = 1'b1;
    case (state)
      tak_pkg::S_M1:  begin mul_a = 33'(g0);  mul_b = 33'(dy);     mul_s32 = 1'b0; end
      tak_pkg::S_M2:  begin mul_a = 33'(g1);  mul_b = 33'(dy);     mul_s32 = 1'b0; end
      tak_pkg::S_M3:  begin mul_a = 33'(g0);  mul_b = 33'(cov_00); mul_s32 = 1'b0; end
      tak_pkg::S_M4:  begin mul_a = 33'(g0);  mul_b = 33'(cov_01); mul_s32 = 1'b0; end
      tak_pkg::S_M5:  begin mul_a = 33'(g1);  mul_b = 33'(cov_00); mul_s32 = 1'b0; end
      tak_pkg::S_M6:  begin mul_a = 33'(g1);  mul_b = 33'(cov_01); mul_s32 = 1'b0; end
      tak_pkg::S_M7:  begin mul_a = 33'(eb);  mul_b = {1'b0, update_interval}; end
      tak_pkg::S_M8:  begin mul_a = 33'(u);   mul_b = {1'b0, update_interval}; end
      tak_pkg::S_M9:  begin mul_a = 33'(q10); mul_b = {1'b0, update_interval}; end
      tak_pkg::S_M10: begin mul_a = 33'(q11); mul_b = {1'b0, update_interval}; end
      tak_pkg::S_M11: begin
        mul_a = {1'b0, update_interval};
        mul_b = {1'b0, update_interval};
      end
      tak_pkg::S_M12: begin mul_a = 33'(m01); mul_b = {1'b0, update_interval}; end
      tak_pkg::S_M13: begin mul_a = {2'b0, rate_variance}; mul_b = {1'b0, dd}; end
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    prod  <= PW'(mul_a) * PW'(mul_b);
    rsh32 <= mul_s32;
  end

  // Round to nearest with halves up: add half an LSB, then floor shift.
  always_comb begin
    if (rsh32) r = SW'((prod + PW'(66'sd2147483648)) >>> 32);
    else r = SW'((prod + (PW'(1) <<< (FB - 1))) >>> FB);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meas_variance   <= 31'(32'd1 << FB);
      rate_variance   <= 31'(32'd1 << FB);
      initial_bias    <= '0;
      update_interval <= 32'd10737418;
      pred_angle      <= '0;
      pred_bias       <= '0;
      cov_00          <= 32'(64'sd1 <<< FB);
      cov_01          <= '0;
      cov_10          <= '0;
      cov_11          <= 32'(64'sd1 <<< FB);
      result.valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (tak_pkg::reg_idx_t'(cfg_index))
          tak_pkg::REG_MEAS_VAR:  meas_variance   <= cfg_data[30:0];
          tak_pkg::REG_RATE_VAR:  rate_variance   <= cfg_data[30:0];
          tak_pkg::REG_INIT_BIAS: initial_bias    <= cfg_data;
          tak_pkg::REG_INTERVAL:  update_interval <= cfg_data;
          default: begin end
        endcase
      end
      if (load_out) begin
        result.valid     <= 1'b1;
        result.est_angle <= ea;
        result.est_bias  <= eb;
        result.saturated <= flag;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        tak_pkg::S_IDLE: begin
          y    <= sample.meas_angle;
          u    <= sample.gyro_rate;
          g0   <= '0;
          g1   <= '0;
          // A zero gain denominator skips both divisions and flags the item.
          flag <= accept && !sample.req_type && (den == '0);
          if (accept && sample.req_type) begin
            pred_angle <= '0;
            pred_bias  <= initial_bias;
            cov_00     <= 32'(64'sd1 <<< FB);
            cov_01     <= '0;
            cov_10     <= '0;
            cov_11     <= 32'({1'b0, rate_variance});
            ea         <= '0;
            eb         <= initial_bias;
          end
        end
        tak_pkg::S_W0: if (div_rsp.done) begin
          g0   <= div_rsp.quo;
          flag <= flag | div_rsp.ovf;
        end
        tak_pkg::S_W1: if (div_rsp.done) begin
          g1   <= div_rsp.quo;
          flag <= flag | div_rsp.ovf;
        end
        tak_pkg::S_DY: begin
          dy   <= tak_pkg::sat32(SW'(y) - SW'(pred_angle));
          flag <= flag | tak_pkg::ovf32(SW'(y) - SW'(pred_angle));
        end
        tak_pkg::S_M2: begin
          ea   <= tak_pkg::sat32(SW'(pred_angle) + r);
          flag <= flag | tak_pkg::ovf32(SW'(pred_angle) + r);
        end
        tak_pkg::S_M3: begin
          eb   <= tak_pkg::sat32(SW'(pred_bias) + r);
          flag <= flag | tak_pkg::ovf32(SW'(pred_bias) + r);
        end
        tak_pkg::S_M4: begin
          q00  <= tak_pkg::sat32(SW'(cov_00) - r);
          flag <= flag | tak_pkg::ovf32(SW'(cov_00) - r);
        end
        tak_pkg::S_M5: begin
          q01  <= tak_pkg::sat32(SW'(cov_01) - r);
          flag <= flag | tak_pkg::ovf32(SW'(cov_01) - r);
        end
        tak_pkg::S_M6: begin
          q10  <= tak_pkg::sat32(SW'(cov_10) - r);
          flag <= flag | tak_pkg::ovf32(SW'(cov_10) - r);
        end
        tak_pkg::S_M7: begin
          q11  <= tak_pkg::sat32(SW'(cov_11) - r);
          flag <= flag | tak_pkg::ovf32(SW'(cov_11) - r);
        end
        // The angle prediction saturates only after both interval terms.
        tak_pkg::S_M8: t <= SW'(ea) - r;
        tak_pkg::S_M9: begin
          pred_angle <= tak_pkg::sat32(t + r);
          flag       <= flag | tak_pkg::ovf32(t + r);
        end
        tak_pkg::S_M10: begin
          m00  <= tak_pkg::sat32(SW'(q00) - r);
          flag <= flag | tak_pkg::ovf32(SW'(q00) - r);
        end
        tak_pkg::S_M11: begin
          m01  <= tak_pkg::sat32(SW'(q01) - r);
          n10  <= tak_pkg::sat32(SW'(q10) - r);
          flag <= flag | tak_pkg::ovf32(SW'(q01) - r) | tak_pkg::ovf32(SW'(q10) - r);
        end
        tak_pkg::S_M12: dd <= r[31:0];
        tak_pkg::S_M13: begin
          n00  <= tak_pkg::sat32(SW'(m00) - r);
          flag <= flag | tak_pkg::ovf32(SW'(m00) - r);
        end
        tak_pkg::S_M14: begin
          cov_00    <= tak_pkg::sat32(SW'(n00) + r);
          flag      <= flag | tak_pkg::ovf32(SW'(n00) + r);
          cov_01    <= m01;
          cov_10    <= n10;
          cov_11    <= q11;
          pred_bias <= eb;
        end
        default: begin end
      endcase
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !sample.ready)
    else $error("second item accepted while one is in work");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == tak_pkg::S_W0 || state == tak_pkg::S_W1))
    else $error("divider finished outside a wait step");

  a_no_zero_div: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> den != '0)
    else $error("division started with a zero denominator");

endmodule
`default_nettype wire
